// ----- hw/rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// Min-heap queue package
// Shared types and constants for the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int Capacity  = 1024;
    localparam int DataWidth = 32;
    localparam int AddrWidth = $clog2(Capacity);
    localparam int CountWidth = $clog2(Capacity + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STATUS_DONE       = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_NONE = 2'd2;

    typedef struct packed {
        logic                        command;
        logic signed [DataWidth-1:0] data_value;
    } in_req_t;

    typedef struct packed {
        logic signed [DataWidth-1:0] top_value;
        logic                        is_empty;
        logic [CountWidth-1:0]       entry_count;
        logic [1:0]                  status;
    } out_req_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [DataWidth-1:0] value;
        logic [1:0]           status;
    } job_t;

endpackage

// ----- hw/rtl/bmhq_front.sv -----
// ----------------------------------------------------------------------------
// Min-heap queue front end
// Accepts requests, checks them against the count that will hold once all
// queued jobs are done, and queues classified jobs for the back end.
// ----------------------------------------------------------------------------
module bmhq_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bmhq_pkg::in_req_t               in_data,
    output logic                            job_valid,
    input  logic                            job_take,
    output bmhq_pkg::job_t                  job
);

    logic [1:0]                         q_valid_reg, q_valid_next;
    bmhq_pkg::job_t                     q_reg [2];
    logic                               wr_ptr_reg, rd_ptr_reg;
    logic [bmhq_pkg::CountWidth-1:0]    proj_count_reg, proj_count_next;
    logic                               accept;
    bmhq_pkg::job_t                     new_job;

    assign in_stall  = q_valid_reg[wr_ptr_reg];
    assign accept    = in_valid && !in_stall;
    assign job_valid = q_valid_reg[rd_ptr_reg];
    assign job       = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_job.value = in_data.data_value;
        new_job.op = bmhq_pkg::OP_NONE;
        new_job.status = bmhq_pkg::STATUS_DONE;
        proj_count_next = proj_count_reg;
        if (in_data.command == bmhq_pkg::CMD_PUSH)
        begin
            if (proj_count_reg == bmhq_pkg::CountWidth'(bmhq_pkg::Capacity))
            begin
                new_job.status = bmhq_pkg::STATUS_PUSH_FULL;
            end
            else
            begin
                new_job.op = bmhq_pkg::OP_PUSH;
                if (accept)
                begin
                    proj_count_next = proj_count_reg + 1'b1;
                end
            end
        end
        else
        begin
            if (proj_count_reg == '0)
            begin
                new_job.status = bmhq_pkg::STATUS_POP_EMPTY;
            end
            else
            begin
                new_job.op = bmhq_pkg::OP_POP;
                if (accept)
                begin
                    proj_count_next = proj_count_reg - 1'b1;
                end
            end
        end
        q_valid_next = q_valid_reg;
        if (job_take)
        begin
            q_valid_next[rd_ptr_reg] = 1'b0;
        end
        if (accept)
        begin
            q_valid_next[wr_ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg    <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            proj_count_reg <= '0;
        end
        else
        begin
            q_valid_reg    <= q_valid_next;
            proj_count_reg <= proj_count_next;
            if (accept)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (job_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ----- hw/rtl/bmhq_back.sv -----
// ----------------------------------------------------------------------------
// Min-heap queue back end
// Runs sift-up and sift-down over the heap memory, one read or one write per
// cycle, and keeps the root in a register for the result.
// ----------------------------------------------------------------------------
module bmhq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_take,
    input  bmhq_pkg::job_t     job,
    output logic               out_valid,
    input  logic               out_stall,
    output bmhq_pkg::out_req_t out_data
);

    localparam int AW = bmhq_pkg::AddrWidth;
    localparam int DW = bmhq_pkg::DataWidth;
    localparam int CW = bmhq_pkg::CountWidth;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_UP_RD  = 4'd1;
    localparam logic [3:0] ST_UP_CMP = 4'd2;
    localparam logic [3:0] ST_POP_RD = 4'd3;
    localparam logic [3:0] ST_POP_WR = 4'd4;
    localparam logic [3:0] ST_DN_RDL = 4'd5;
    localparam logic [3:0] ST_DN_RDR = 4'd6;
    localparam logic [3:0] ST_DN_CMP = 4'd7;
    localparam logic [3:0] ST_DN_CMP2 = 4'd8;
    localparam logic [3:0] ST_DONE   = 4'd9;
    localparam logic [3:0] ST_UP_ROOT = 4'd10;

    logic [DW-1:0] mem [bmhq_pkg::Capacity];
    logic [DW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] child_reg, child_next;
    logic [DW-1:0] val_reg, val_next;
    logic [DW-1:0] left_reg, left_next;
    logic [DW-1:0] root_reg, root_next;
    logic [1:0]    status_reg, status_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] top_reg, top_next;
    logic [CW-1:0] ocount_reg, ocount_next;
    logic [1:0]    ostatus_reg, ostatus_next;

    logic [AW-1:0] parent;
    logic [CW:0]   left_idx;
    logic          pick_right;
    logic [DW-1:0] small_val;
    logic          busy_out;

    assign parent   = AW'((pos_reg - 1'b1) >> 1);
    assign left_idx = {1'b0, pos_reg, 1'b1};
    assign busy_out = out_valid_reg && out_stall;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        child_next     = child_reg;
        val_next       = val_reg;
        left_next      = left_reg;
        root_next      = root_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        top_next       = top_reg;
        ocount_next    = ocount_reg;
        ostatus_next   = ostatus_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg;
        mem_wdata      = val_reg;
        mem_raddr      = parent;
        job_take       = 1'b0;
        pick_right     = ($signed(left_reg) > $signed(rd_data_reg));
        small_val      = pick_right ? rd_data_reg : left_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take    = 1'b1;
                    status_next = job.status;
                    val_next    = job.value;
                    case (job.op)
                        bmhq_pkg::OP_PUSH:
                        begin
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + 1'b1;
                            state_next = (count_reg == '0) ? ST_DONE : ST_UP_RD;
                            if (count_reg == '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = job.value;
                                root_next = job.value;
                            end
                        end
                        bmhq_pkg::OP_POP:
                        begin
                            count_next = count_reg - 1'b1;
                            state_next = (count_reg == CW'(1)) ? ST_DONE : ST_POP_RD;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                mem_raddr  = parent;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                if ($signed(val_reg) < $signed(rd_data_reg))
                begin
                    mem_waddr = pos_reg;
                    mem_wdata = rd_data_reg;
                    pos_next  = parent;
                    if (parent == '0)
                    begin
                        state_next = ST_UP_ROOT;
                        root_next  = val_reg;
                        pos_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_UP_RD;
                    end
                end
                else
                begin
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    state_next = ST_DONE;
                end
                if (state_next == ST_DONE && $signed(val_reg) < $signed(rd_data_reg))
                begin
                    mem_we = 1'b1;
                end
            end
            ST_UP_ROOT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = val_reg;
                state_next = ST_DONE;
            end
            ST_POP_RD:
            begin
                mem_raddr  = AW'(count_reg);
                state_next = ST_POP_WR;
            end
            ST_POP_WR:
            begin
                val_next   = rd_data_reg;
                pos_next   = '0;
                state_next = ST_DN_RDL;
            end
            ST_DN_RDL:
            begin
                if (left_idx >= {1'b0, count_reg})
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    if (pos_reg == '0)
                    begin
                        root_next = val_reg;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_raddr  = AW'(left_idx);
                    child_next = AW'(left_idx);
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR:
            begin
                left_next = rd_data_reg;
                if ((left_idx + 1'b1) >= {1'b0, count_reg})
                begin
                    state_next = ST_DN_CMP2;
                end
                else
                begin
                    mem_raddr  = AW'(left_idx + 1'b1);
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP, ST_DN_CMP2:
            begin
                if (state_reg == ST_DN_CMP2)
                begin
                    pick_right = 1'b0;
                    small_val  = left_reg;
                end
                if ($signed(small_val) < $signed(val_reg))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = small_val;
                    if (pos_reg == '0)
                    begin
                        root_next = small_val;
                    end
                    pos_next   = pick_right ? child_reg + 1'b1 : child_reg;
                    state_next = ST_DN_RDL;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg;
                    mem_wdata  = val_reg;
                    if (pos_reg == '0)
                    begin
                        root_next = val_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!busy_out)
                begin
                    out_valid_next = 1'b1;
                    top_next       = (count_reg == '0) ? '0 : root_reg;
                    ocount_next    = count_reg;
                    ostatus_next   = status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        child_reg   <= child_next;
        val_reg     <= val_next;
        left_reg    <= left_next;
        root_reg    <= root_next;
        status_reg  <= status_next;
        top_reg     <= top_next;
        ocount_reg  <= ocount_next;
        ostatus_reg <= ostatus_next;
    end

    assign out_valid            = out_valid_reg;
    assign out_data.top_value   = top_reg;
    assign out_data.is_empty    = (ocount_reg == '0);
    assign out_data.entry_count = ocount_reg;
    assign out_data.status      = ostatus_reg;

endmodule

// ----- hw/rtl/binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// Binary min-heap queue
// Priority queue of signed values with push and pop, one result per request.
//
// Channel  Signals                         Direction
// in       in_valid, in_stall, in_data      request in
// out      out_valid, out_stall, out_data   result out
//
// A push climbs one level per pass through ST_UP_RD and ST_UP_CMP, a pop
// descends one level per pass through ST_DN_RDL, ST_DN_RDR and ST_DN_CMP.
// Rejected requests, pushes to an empty heap and pops to empty go to ST_DONE.
// Reset empties the heap. Two requests can wait in the queue between front
// and back, and one result waits in the output register under out_stall.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bmhq_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bmhq_pkg::out_req_t out_data
);

    logic           job_valid;
    logic           job_take;
    bmhq_pkg::job_t job;

    bmhq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    bmhq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> job_valid)
        else $error("job taken while queue empty");

    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.is_empty == (out_data.entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.is_empty) |-> (out_data.top_value == '0))
        else $error("top nonzero on empty heap");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Min-heap queue testbench
// Drives push and pop requests into the heap queue, with random idling on
// both channels in part of the run, predicts every result with a behavioral
// heap and compares each result field by field in order.
// ----------------------------------------------------------------------------
class heap_scoreboard;

    logic signed [31:0] heap_vals[$];
    bmhq_pkg::out_req_t pending_results[$];
    int mismatch_count;

    function void note_request(bmhq_pkg::in_req_t req);
        bmhq_pkg::out_req_t res;
        int idx;
        int min_idx;
        res.status = bmhq_pkg::STATUS_DONE;
        if (req.command == bmhq_pkg::CMD_PUSH) begin
            if (heap_vals.size() >= bmhq_pkg::Capacity)
                res.status = bmhq_pkg::STATUS_PUSH_FULL;
            else
                heap_vals.push_back(req.data_value);
        end else begin
            if (heap_vals.size() == 0) begin
                res.status = bmhq_pkg::STATUS_POP_EMPTY;
            end else begin
                min_idx = 0;
                for (idx = 1; idx < heap_vals.size(); idx++)
                    if (heap_vals[idx] < heap_vals[min_idx])
                        min_idx = idx;
                heap_vals.delete(min_idx);
            end
        end
        res.top_value = '0;
        for (idx = 0; idx < heap_vals.size(); idx++)
            if (idx == 0 || heap_vals[idx] < res.top_value)
                res.top_value = heap_vals[idx];
        res.is_empty = (heap_vals.size() == 0);
        res.entry_count = bmhq_pkg::CountWidth'(heap_vals.size());
        pending_results.push_back(res);
    endfunction

    function void check_result(bmhq_pkg::out_req_t got);
        bmhq_pkg::out_req_t want;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected result: %p", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.top_value !== want.top_value || got.is_empty !== want.is_empty
                || got.entry_count !== want.entry_count || got.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch: expected %p, got %p", want, got);
        end
    endfunction

endclass

module testbench;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    bmhq_pkg::in_req_t in_data;
    logic out_valid;
    logic out_stall;
    bmhq_pkg::out_req_t out_data;
    logic idle_enable;
    heap_scoreboard board;

    binary_min_heap_queue dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_enable && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input logic cmd, input logic signed [31:0] val);
        int burst;
        if (idle_enable && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (burst) @(negedge clk);
        end
        in_data.command <= cmd;
        in_data.data_value <= val;
        in_valid <= 1'b1;
        while (in_stall) @(negedge clk);
        @(posedge clk);
        board.note_request(in_data);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    initial
    begin
        int idx;
        int fill;
        board = new();
        idle_enable = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(bmhq_pkg::CMD_POP, 32'sd5);
        send_request(bmhq_pkg::CMD_PUSH, 32'sh7fffffff);
        send_request(bmhq_pkg::CMD_PUSH, 32'sh80000000);
        send_request(bmhq_pkg::CMD_PUSH, 32'sd0);
        send_request(bmhq_pkg::CMD_PUSH, -32'sd1);
        send_request(bmhq_pkg::CMD_PUSH, -32'sd1);
        send_request(bmhq_pkg::CMD_PUSH, 32'sh80000000);
        for (idx = 0; idx < 7; idx++)
            send_request(bmhq_pkg::CMD_POP, 32'shffffffff);

        idle_enable = 1'b1;
        for (idx = 0; idx < 300; idx++)
            send_request($urandom_range(0, 2) == 0, random_value());
        wait_drained();

        fill = bmhq_pkg::Capacity + 3 - board.heap_vals.size();
        for (idx = 0; idx < fill; idx++)
            send_request(bmhq_pkg::CMD_PUSH, random_value());
        for (idx = 0; idx < 100; idx++)
            send_request($urandom_range(0, 3) == 0, random_value());

        idle_enable = 1'b0;
        for (idx = 0; idx < 450; idx++)
            send_request($urandom_range(0, 9) == 0 ? bmhq_pkg::CMD_PUSH : bmhq_pkg::CMD_POP,
                         random_value());
        for (idx = 0; idx < 60; idx++)
            send_request(1'($urandom_range(0, 1)), random_value());

        in_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (board.mismatch_count == 0 && board.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- binary_min_heap_queue.f -----
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_front.sv
hw/rtl/bmhq_back.sv
hw/rtl/binary_min_heap_queue.sv
bench/testbench.sv
